### design/pvs_pkg.sv
// ---------------------------------------------------------------------------
// pvs_pkg
// Shared constants, types and the arctangent table for the polar vector adder.
// ---------------------------------------------------------------------------
package pvs_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN         = 24;
	localparam int GUARD            = 12;
	localparam int HALF_TURN        = 11520;
	localparam int FULL_TURN        = 23040;
	localparam int QUARTER_TURN     = 5760;
	localparam int XW               = 34;	// CORDIC coordinate width
	localparam int ZW               = 26;	// CORDIC angle width, 2^-16 degree
	localparam logic signed [31:0] INVK = 32'sd652032874;

	// side information carried through the vectoring CORDIC
	typedef struct packed {
		logic signed [17:0] sx;
		logic signed [17:0] sy;
		logic               zero;
		logic               left;
		logic               ypos;
	} vec_side_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic int atan_at(input int i);
		int r;
		unique case (i)
			0:  r = 2949120;
			1:  r = 1740967;
			2:  r = 919879;
			3:  r = 466945;
			4:  r = 234379;
			5:  r = 117304;
			6:  r = 58666;
			7:  r = 29335;
			8:  r = 14668;
			9:  r = 7334;
			10: r = 3667;
			11: r = 1833;
			12: r = 917;
			13: r = 458;
			14: r = 229;
			15: r = 115;
			16: r = 57;
			17: r = 29;
			18: r = 14;
			19: r = 7;
			20: r = 4;
			21: r = 2;
			22: r = 1;
			default: r = 0;
		endcase
		return r;
	endfunction

endpackage

### design/pvs_if.sv
// ---------------------------------------------------------------------------
// pvs_if
// Valid/ready channels for the vector pair input and the resultant output.
// ---------------------------------------------------------------------------
interface pvs_in_if;
	logic               valid;
	logic               ready;
	logic        [15:0] first_length;
	logic signed [15:0] first_angle;
	logic        [15:0] second_length;
	logic signed [15:0] second_angle;

	modport source (output valid, first_length, first_angle, second_length, second_angle,
		input ready);
	modport sink (input valid, first_length, first_angle, second_length, second_angle,
		output ready);
endinterface

interface pvs_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] sum_x;
	logic signed [17:0] sum_y;
	logic        [16:0] magnitude;
	logic signed [14:0] direction;
	logic               zero_vector;

	modport source (output valid, sum_x, sum_y, magnitude, direction, zero_vector,
		input ready);
	modport sink (input valid, sum_x, sum_y, magnitude, direction, zero_vector,
		output ready);
endinterface

### design/pvs_cordic.sv
// ---------------------------------------------------------------------------
// pvs_cordic
// Unrolled CORDIC, one register stage per iteration, rotation or vectoring.
// ---------------------------------------------------------------------------
module pvs_cordic
	import pvs_pkg::*;
#(
	parameter int STEPS  = CORDIC_STEPS_DEF,
	parameter int SW     = 1,
	parameter bit VECTOR = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic        [SW-1:0] side_in,
	output logic                 valid_out,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic        [SW-1:0] side_out
);

	localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

	logic                 vld_s  [NSTEP+1];
	logic signed [XW-1:0] x_s    [NSTEP+1];
	logic signed [XW-1:0] y_s    [NSTEP+1];
	logic signed [ZW-1:0] z_s    [NSTEP+1];
	logic        [SW-1:0] side_s [NSTEP+1];

	assign vld_s[0]  = valid_in;
	assign x_s[0]    = x_in;
	assign y_s[0]    = y_in;
	assign z_s[0]    = z_in;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam logic signed [ZW-1:0] ANG = ZW'(atan_at(k));
		logic                 pos;
		logic signed [XW-1:0] xsh, ysh;

		// rotate towards zero residual angle, or towards the X axis when vectoring
		assign pos = VECTOR ? y_s[k][XW-1] : ~z_s[k][ZW-1];
		assign xsh = x_s[k] >>> k;
		assign ysh = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					x_s[k+1] <= x_s[k] - ysh;
					y_s[k+1] <= y_s[k] + xsh;
					z_s[k+1] <= z_s[k] - ANG;
				end else begin
					x_s[k+1] <= x_s[k] + ysh;
					y_s[k+1] <= y_s[k] - xsh;
					z_s[k+1] <= z_s[k] + ANG;
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid_out = vld_s[NSTEP];
	assign x_out     = x_s[NSTEP];
	assign y_out     = y_s[NSTEP];
	assign z_out     = z_s[NSTEP];
	assign side_out  = side_s[NSTEP];

endmodule

### design/polar_vector_sum.sv
// ---------------------------------------------------------------------------
// polar_vector_sum
// Adds two polar vectors through rotation CORDICs and returns the Cartesian
// sum with its magnitude and direction from a vectoring CORDIC.
// ---------------------------------------------------------------------------
//  channel   dir  words
//  vec_in    in   first/second length (Q4) and angle (Q6 degrees)
//  sum_out   out  sum_x, sum_y, magnitude, direction, zero_vector
//
//  One word is taken every cycle unless the output stalls; the two unrolled
//  CORDIC chains hold one register per iteration.
//  Reset clears only the valid bits of the pipeline.
//  A stalled output holds the whole pipeline; vec_in.ready falls with it.
// ---------------------------------------------------------------------------
module polar_vector_sum
	import pvs_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pvs_in_if.sink    vec_in,
	pvs_out_if.source sum_out
);

	typedef struct packed {
		logic               flip;
		logic signed [ZW-1:0] z;
	} prep_t;

	function automatic prep_t prep(input logic signed [15:0] ang);
		logic signed [16:0] a;
		prep_t r;
		a = 17'(ang);
		if (a > 17'sd11520) a = a - 17'sd23040;
		else if (a <= -17'sd11520) a = a + 17'sd23040;
		r.flip = 1'b0;
		if (a > 17'sd5760) begin
			a = a - 17'sd11520;
			r.flip = 1'b1;
		end else if (a < -17'sd5760) begin
			a = a + 17'sd11520;
			r.flip = 1'b1;
		end
		r.z = ZW'($signed({a, 10'b0}));
		return r;
	endfunction

	function automatic logic signed [XW-1:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd536870912 - $signed({63'b0, p[63]});
		return XW'(t >>> 30);
	endfunction

	logic en;
	logic out_vld_q;

	assign en           = ~out_vld_q | sum_out.ready;
	assign vec_in.ready = en;

	// ---- stage 1: wrap and fold angles
	prep_t p1, p2;
	assign p1 = prep(vec_in.first_angle);
	assign p2 = prep(vec_in.second_angle);

	logic                 vld_s1;
	logic signed [XW-1:0] x1_s1, x2_s1;
	prep_t                p1_s1, p2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vec_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= XW'({vec_in.first_length, 12'b0});
			x2_s1 <= XW'({vec_in.second_length, 12'b0});
			p1_s1 <= p1;
			p2_s1 <= p2;
		end
	end

	// ---- rotation CORDICs
	logic                 vld_r;
	logic signed [XW-1:0] rx1, ry1, rx2, ry2;
	logic                 f1_r, f2_r;

	pvs_cordic #(.STEPS(CORDIC_STEPS), .SW(1), .VECTOR(1'b0)) u_rot1 (
		.clk, .arst_n, .en,
		.valid_in(vld_s1), .x_in(x1_s1), .y_in('0), .z_in(p1_s1.z), .side_in(p1_s1.flip),
		.valid_out(vld_r), .x_out(rx1), .y_out(ry1), .z_out(), .side_out(f1_r)
	);

	pvs_cordic #(.STEPS(CORDIC_STEPS), .SW(1), .VECTOR(1'b0)) u_rot2 (
		.clk, .arst_n, .en,
		.valid_in(vld_s1), .x_in(x2_s1), .y_in('0), .z_in(p2_s1.z), .side_in(p2_s1.flip),
		.valid_out(), .x_out(rx2), .y_out(ry2), .z_out(), .side_out(f2_r)
	);

	// ---- stage 2: remove gain
	logic               vld_s2, f1_s2, f2_s2;
	logic signed [63:0] px1_s2, py1_s2, px2_s2, py2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px1_s2 <= 64'(rx1) * 64'(INVK);
			py1_s2 <= 64'(ry1) * 64'(INVK);
			px2_s2 <= 64'(rx2) * 64'(INVK);
			py2_s2 <= 64'(ry2) * 64'(INVK);
			f1_s2  <= f1_r;
			f2_s2  <= f2_r;
		end
	end

	// ---- stage 3: round, undo fold, add components
	logic signed [XW-1:0] cx1, cy1, cx2, cy2;
	assign cx1 = f1_s2 ? -rnd30(px1_s2) : rnd30(px1_s2);
	assign cy1 = f1_s2 ? -rnd30(py1_s2) : rnd30(py1_s2);
	assign cx2 = f2_s2 ? -rnd30(px2_s2) : rnd30(px2_s2);
	assign cy2 = f2_s2 ? -rnd30(py2_s2) : rnd30(py2_s2);

	logic                 vld_s3;
	logic signed [XW:0]   sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3 <= (XW+1)'(cx1) + (XW+1)'(cx2);
			sy_s3 <= (XW+1)'(cy1) + (XW+1)'(cy2);
		end
	end

	// ---- stage 4: drop guard bits and saturate
	function automatic logic signed [17:0] rnd_sat(input logic signed [XW:0] v);
		logic signed [XW:0] t, q;
		t = v + (XW+1)'(2048) - $signed({{XW{1'b0}}, v[XW]});
		q = t >>> GUARD;
		if (q > (XW+1)'(131071)) return 18'sd131071;
		if (q < -(XW+1)'(131071)) return -18'sd131071;
		return 18'(q);
	endfunction

	logic               vld_s4;
	logic signed [17:0] sx_s4, sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s4 <= rnd_sat(sx_s3);
			sy_s4 <= rnd_sat(sy_s3);
		end
	end

	// ---- vectoring CORDIC, left half-plane mirrored
	vec_side_t            vside_in, vside_out;
	logic signed [XW-1:0] vx_in, vy_in, vx_out;
	logic signed [ZW-1:0] vz_out;
	logic                 vld_v;

	always_comb begin
		vside_in.sx   = sx_s4;
		vside_in.sy   = sy_s4;
		vside_in.zero = (sx_s4 == '0) && (sy_s4 == '0);
		vside_in.left = sx_s4[17];
		vside_in.ypos = ~sy_s4[17];
		vx_in = XW'($signed({sx_s4, 12'b0}));
		vy_in = XW'($signed({sy_s4, 12'b0}));
		if (sx_s4[17]) begin
			vx_in = -vx_in;
			vy_in = -vy_in;
		end
	end

	pvs_cordic #(.STEPS(CORDIC_STEPS), .SW($bits(vec_side_t)), .VECTOR(1'b1)) u_vec (
		.clk, .arst_n, .en,
		.valid_in(vld_s4), .x_in(vx_in), .y_in(vy_in), .z_in('0), .side_in(vside_in),
		.valid_out(vld_v), .x_out(vx_out), .y_out(), .z_out(vz_out), .side_out(vside_out)
	);

	// ---- stage 5: magnitude product, direction sum
	localparam logic signed [ZW:0] BASE = (ZW+1)'(HALF_TURN * 1024);

	logic               vld_s5;
	logic signed [63:0] pm_s5;
	logic signed [ZW:0] dsum_s5;
	vec_side_t          side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s5   <= 64'(vx_out) * 64'(INVK);
			dsum_s5 <= (ZW+1)'(vz_out) +
				(vside_out.left ? (vside_out.ypos ? BASE : -BASE) : '0);
			side_s5 <= vside_out;
		end
	end

	// ---- stage 6: output register
	logic signed [63:0] mt;
	logic signed [63:0] mq;
	logic signed [ZW:0] dt, dq;
	logic signed [ZW:0] dw;

	always_comb begin
		mt = pm_s5 + 64'sh200_0000_0000;
		mq = mt >>> (30 + GUARD);
		dt = dsum_s5 + (ZW+1)'(512) - $signed({{ZW{1'b0}}, dsum_s5[ZW]});
		dq = dt >>> 10;
		dw = dq;
		if (dq > (ZW+1)'(HALF_TURN)) dw = dq - (ZW+1)'(FULL_TURN);
		else if (dq <= -(ZW+1)'(HALF_TURN)) dw = dq + (ZW+1)'(FULL_TURN);
	end

	logic signed [17:0] sx_q, sy_q;
	logic        [16:0] mag_q;
	logic signed [14:0] dir_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_q   <= side_s5.sx;
			sy_q   <= side_s5.sy;
			zero_q <= side_s5.zero;
			if (side_s5.zero) begin
				mag_q <= '0;
				dir_q <= '0;
			end else begin
				mag_q <= (mq > 64'sd131071) ? 17'd131071 : 17'(mq);
				dir_q <= 15'(dw);
			end
		end
	end

	assign sum_out.valid       = out_vld_q;
	assign sum_out.sum_x       = sx_q;
	assign sum_out.sum_y       = sy_q;
	assign sum_out.magnitude   = mag_q;
	assign sum_out.direction   = dir_q;
	assign sum_out.zero_vector = zero_q;

	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		sum_out.valid && sum_out.zero_vector |-> sum_out.magnitude == '0 &&
			sum_out.direction == '0)
		else $error("zero resultant with nonzero magnitude or direction");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		sum_out.valid |-> sum_out.zero_vector ==
			(sum_out.sum_x == '0 && sum_out.sum_y == '0))
		else $error("zero flag disagrees with components");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_out.valid |-> sum_out.direction > -15'sd11520 &&
			sum_out.direction <= 15'sd11520)
		else $error("direction out of range");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !sum_out.ready |=> out_vld_q)
		else $error("result dropped while stalled");

endmodule
